// ===== hw/rtl/avp_pkg.sv =====
// avp_pkg: shared types and character constants for the address text validator
// no dependencies; imported by every rtl module
`default_nettype none

package avp_pkg;

   // ascii codes used by the character classes
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   // limits of the dotted quad and hex group checks
   localparam logic [9:0] OCTET_MAX      = 10'd255;
   localparam logic [2:0] QUAD_DIGIT_MAX = 3'd3;
   localparam logic [2:0] QUAD_GROUPS    = 3'd4;
   localparam logic [2:0] HEX_DIGIT_MAX  = 3'd4;
   localparam logic [3:0] HEX_GROUPS     = 4'd8;
   localparam logic [3:0] HEX_GROUPS_ZR  = 4'd6;

   // address kind codes
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_V4     = 2'd1,
      KIND_V6     = 2'd2,
      KIND_MAPPED = 2'd3
   } kind_type;

   // failure cause codes
   typedef enum logic [1:0] {
      FAIL_NONE   = 2'd0,
      FAIL_CHAR   = 2'd1,
      FAIL_FORMAT = 2'd2,
      FAIL_UNDET  = 2'd3
   } fail_type;

   // colon run codes
   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_ONE  = 2'd1,
      RUN_TWO  = 2'd2
   } run_type;

   // tracker for a leading "::ffff:" prefix
   typedef enum logic [3:0] {
      PH_START     = 4'd0,
      PH_ONE_COLON = 4'd1,
      PH_TWO_COLON = 4'd2,
      PH_F1        = 4'd3,
      PH_F2        = 4'd4,
      PH_F3        = 4'd5,
      PH_F4        = 4'd6,
      PH_PREFIX    = 4'd7,
      PH_MAPPED    = 4'd8,
      PH_DEAD      = 4'd15
   } prefix_type;

   // verdict handed from the scanner to the response register
   typedef struct packed {
      logic     addr_valid;
      kind_type addr_kind;
      fail_type fail_cause;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/avp_req_if.sv =====
// avp_req_if: character channel, valid/ready with one character per transaction
// depends on nothing but the handshake convention
`default_nettype none

interface avp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/avp_rsp_if.sv =====
// avp_rsp_if: verdict channel, valid/ready with one verdict per transaction
// depends on nothing but the handshake convention
`default_nettype none

interface avp_rsp_if;
   logic       valid;
   logic       ready;
   logic       addr_valid;
   logic [1:0] addr_kind;
   logic [1:0] fail_cause;

   modport source (output valid, output addr_valid, output addr_kind, output fail_cause,
                   input ready);
   modport sink   (input valid, input addr_valid, input addr_kind, input fail_cause,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/avp_scan.sv =====
// avp_scan: per-character state of the ipv4 and ipv6 checkers and the verdict logic
// depends on avp_pkg
`default_nettype none

module avp_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         char_code,
   input  wire logic               last_char,
   output avp_pkg::result_type     result
);
   import avp_pkg::*;

   // state registers
   kind_type   kind_seen_ff, kind_seen_in;
   logic [2:0] quad_digits_ff, quad_digits_in;
   logic [9:0] quad_value_ff, quad_value_in;
   logic [2:0] quad_groups_ff, quad_groups_in;
   fail_type   quad_fail_ff, quad_fail_in;
   kind_type   rest_kind_ff, rest_kind_in;
   logic [2:0] hex_digits_ff, hex_digits_in;
   logic [3:0] hex_groups_ff, hex_groups_in;
   logic       zero_run_used_ff, zero_run_used_in;
   run_type    colon_run_ff, colon_run_in;
   fail_type   fail_code_ff, fail_code_in;
   prefix_type prefix_ff, prefix_in;

   // character classes
   logic       is_dec, is_hexl, is_colon, is_dot, is_f;
   kind_type   dec_kind;
   logic       quad_restart;

   // quad checker base after an optional restart
   logic [2:0] qb_digits;
   logic [9:0] qb_value;
   logic [2:0] qb_groups;
   fail_type   qb_fail;
   kind_type   rest_base;
   logic [13:0] times_ten;

   fail_type   quad_cause, hex_cause;

   assign is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_hexl  = ((char_code >= CH_LO_A) && (char_code <= CH_LO_F)) ||
                     ((char_code >= CH_UP_A) && (char_code <= CH_UP_F));
   assign is_colon = (char_code == CH_COLON);
   assign is_dot   = (char_code == CH_DOT);
   assign is_f     = (char_code == CH_LO_F) || (char_code == CH_UP_F);

   // deciding character
   always_comb begin
      if (is_dot) begin
         dec_kind = KIND_V4;
      end else if (is_hexl || is_colon) begin
         dec_kind = KIND_V6;
      end else begin
         dec_kind = KIND_NONE;
      end
   end

   assign kind_seen_in = (kind_seen_ff == KIND_NONE) ? dec_kind : kind_seen_ff;

   // prefix tracker next state
   always_comb begin
      unique case (prefix_ff)
         PH_START, PH_ONE_COLON, PH_F4: begin
            prefix_in = is_colon ? prefix_type'(prefix_ff + 4'd1) : PH_DEAD;
         end
         PH_TWO_COLON, PH_F1, PH_F2, PH_F3: begin
            prefix_in = is_f ? prefix_type'(prefix_ff + 4'd1) : PH_DEAD;
         end
         PH_PREFIX: begin
            prefix_in = is_colon ? PH_DEAD : PH_MAPPED;
         end
         default: begin
            prefix_in = prefix_ff;
         end
      endcase
   end

   // prefix tracker output: the embedded quad starts over after the prefix
   assign quad_restart = (prefix_ff == PH_PREFIX) && !is_colon;

   // ipv6 group checker
   always_comb begin
      fail_code_in     = fail_code_ff;
      hex_digits_in    = hex_digits_ff;
      hex_groups_in    = hex_groups_ff;
      zero_run_used_in = zero_run_used_ff;
      colon_run_in     = colon_run_ff;
      if (fail_code_ff == FAIL_NONE) begin
         if ((prefix_ff == PH_ONE_COLON) && !is_colon) begin
            fail_code_in = FAIL_FORMAT;
         end else if (is_dec || is_hexl) begin
            colon_run_in  = RUN_NONE;
            hex_digits_in = hex_digits_ff + 3'd1;
            if (hex_digits_ff >= HEX_DIGIT_MAX) begin
               fail_code_in = FAIL_FORMAT;
            end
         end else if (is_colon) begin
            case (colon_run_ff)
               RUN_NONE: begin
                  colon_run_in  = RUN_ONE;
                  hex_groups_in = hex_groups_ff + 4'd1;
                  hex_digits_in = 3'd0;
                  if (hex_groups_ff >= HEX_GROUPS) begin
                     fail_code_in = FAIL_FORMAT;
                  end
               end
               RUN_ONE: begin
                  if (zero_run_used_ff) begin
                     fail_code_in = FAIL_FORMAT;
                  end else begin
                     zero_run_used_in = 1'b1;
                     colon_run_in     = RUN_TWO;
                  end
               end
               default: begin
                  fail_code_in = FAIL_FORMAT;
               end
            endcase
         end else begin
            fail_code_in = FAIL_CHAR;
         end
      end
   end

   // quad checker base values, cleared when the mapped part begins
   always_comb begin
      if (quad_restart) begin
         qb_digits = 3'd0;
         qb_value  = 10'd0;
         qb_groups = 3'd1;
         qb_fail   = FAIL_NONE;
         rest_base = KIND_NONE;
      end else begin
         qb_digits = quad_digits_ff;
         qb_value  = quad_value_ff;
         qb_groups = quad_groups_ff;
         qb_fail   = quad_fail_ff;
         rest_base = rest_kind_ff;
      end
   end

   // value times ten plus the new digit, kept to ten bits
   assign times_ten = {1'b0, qb_value, 3'b000} + {3'b000, qb_value, 1'b0} +
                      {10'd0, char_code[3:0]};

   // ipv4 octet checker
   always_comb begin
      quad_digits_in = qb_digits;
      quad_value_in  = qb_value;
      quad_groups_in = qb_groups;
      quad_fail_in   = qb_fail;
      if (qb_fail == FAIL_NONE) begin
         if (is_dec) begin
            quad_digits_in = qb_digits + 3'd1;
            quad_value_in  = times_ten[9:0];
            if ((qb_digits >= QUAD_DIGIT_MAX) || (qb_groups > QUAD_GROUPS)) begin
               quad_fail_in = FAIL_FORMAT;
            end
         end else if (is_dot) begin
            if ((qb_digits == 3'd0) || (qb_value > OCTET_MAX)) begin
               quad_fail_in = FAIL_FORMAT;
            end else begin
               quad_groups_in = qb_groups + 3'd1;
               quad_digits_in = 3'd0;
               quad_value_in  = 10'd0;
               if (qb_groups >= QUAD_GROUPS) begin
                  quad_fail_in = FAIL_FORMAT;
               end
            end
         end else begin
            quad_fail_in = FAIL_CHAR;
         end
      end
   end

   assign rest_kind_in = ((prefix_in == PH_MAPPED) && (rest_base == KIND_NONE)) ?
                         dec_kind : rest_base;

   // end-of-string checks of both checkers
   always_comb begin
      if (quad_fail_in != FAIL_NONE) begin
         quad_cause = quad_fail_in;
      end else if ((quad_groups_in != QUAD_GROUPS) || (quad_digits_in == 3'd0) ||
                   (quad_value_in > OCTET_MAX)) begin
         quad_cause = FAIL_FORMAT;
      end else begin
         quad_cause = FAIL_NONE;
      end
   end

   always_comb begin
      if (fail_code_in != FAIL_NONE) begin
         hex_cause = fail_code_in;
      end else if (prefix_in == PH_ONE_COLON) begin
         hex_cause = FAIL_FORMAT;
      end else if ((hex_digits_in == 3'd0) && (colon_run_in != RUN_TWO)) begin
         hex_cause = FAIL_FORMAT;
      end else if (zero_run_used_in && (hex_groups_in > HEX_GROUPS_ZR)) begin
         hex_cause = FAIL_FORMAT;
      end else if (!zero_run_used_in && (hex_groups_in != HEX_GROUPS)) begin
         hex_cause = FAIL_FORMAT;
      end else begin
         hex_cause = FAIL_NONE;
      end
   end

   // verdict for a string that ends with this character
   always_comb begin
      if ((prefix_in == PH_MAPPED) && (rest_kind_in == KIND_V4)) begin
         result.addr_kind  = KIND_MAPPED;
         result.fail_cause = quad_cause;
      end else if (kind_seen_in == KIND_V4) begin
         result.addr_kind  = KIND_V4;
         result.fail_cause = quad_cause;
      end else if (kind_seen_in == KIND_V6) begin
         result.addr_kind  = KIND_V6;
         result.fail_cause = hex_cause;
      end else begin
         result.addr_kind  = KIND_NONE;
         result.fail_cause = FAIL_UNDET;
      end
      result.addr_valid = (result.fail_cause == FAIL_NONE);
   end

   // state update, back to start after the last character
   always_ff @(posedge clock) begin
      if (reset || (accept && last_char)) begin
         kind_seen_ff     <= KIND_NONE;
         quad_digits_ff   <= 3'd0;
         quad_value_ff    <= 10'd0;
         quad_groups_ff   <= 3'd1;
         quad_fail_ff     <= FAIL_NONE;
         rest_kind_ff     <= KIND_NONE;
         hex_digits_ff    <= 3'd0;
         hex_groups_ff    <= 4'd1;
         zero_run_used_ff <= 1'b0;
         colon_run_ff     <= RUN_NONE;
         fail_code_ff     <= FAIL_NONE;
         prefix_ff        <= PH_START;
      end else if (accept) begin
         kind_seen_ff     <= kind_seen_in;
         quad_digits_ff   <= quad_digits_in;
         quad_value_ff    <= quad_value_in;
         quad_groups_ff   <= quad_groups_in;
         quad_fail_ff     <= quad_fail_in;
         rest_kind_ff     <= rest_kind_in;
         hex_digits_ff    <= hex_digits_in;
         hex_groups_ff    <= hex_groups_in;
         zero_run_used_ff <= zero_run_used_in;
         colon_run_ff     <= colon_run_in;
         fail_code_ff     <= fail_code_in;
         prefix_ff        <= prefix_in;
      end
   end

`ifndef SYNTH
   // a finished string leaves the checkers at their start state
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last_char) |=> (kind_seen_ff == KIND_NONE) && (prefix_ff == PH_START) &&
                                (fail_code_ff == FAIL_NONE) && (quad_fail_ff == FAIL_NONE))
      else $error("checker state not cleared after end of string");

   // the first ipv6 failure is kept until the string ends
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !last_char && (fail_code_ff != FAIL_NONE)) |=>
         (fail_code_ff == $past(fail_code_ff)))
      else $error("ipv6 failure cause changed mid-string");

   // a mapped verdict only comes out of the prefix path
   a_mapped_path: assert property (@(posedge clock) disable iff (reset)
      (accept && last_char && (result.addr_kind == KIND_MAPPED)) |->
         ((prefix_ff == PH_PREFIX) || (prefix_ff == PH_MAPPED)))
      else $error("mapped kind without the ffff prefix");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/avp_rsp_reg.sv =====
// avp_rsp_reg: output register that holds a verdict until the receiver takes it
// depends on avp_pkg
`default_nettype none

module avp_rsp_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire avp_pkg::result_type result,
   input  wire logic               rsp_ready,
   output logic                    can_take,
   output logic                    rsp_valid,
   output avp_pkg::result_type     rsp_data
);
   import avp_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // room for a new verdict when empty or when the held one leaves now
   assign can_take = !rsp_valid_ff || rsp_ready;

   // valid flag next value
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // verdict payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a loaded verdict is presented on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded verdict not presented");

   // the valid flag of a held verdict agrees with its cause
   a_valid_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.addr_valid == (rsp_data_ff.fail_cause == FAIL_NONE)))
      else $error("verdict valid flag disagrees with fail cause");

   // a verdict the receiver has not taken stays put
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("held verdict changed before it was taken");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ip_address_text_validator_top.sv =====
// ip_address_text_validator_top: checks an ipv4/ipv6 address string one character
// at a time. Characters arrive on req_if, one per transaction, the final one with
// last_char set. Each string yields one verdict transaction on rsp_if: addr_valid,
// addr_kind (undetected, ipv4, ipv6, ipv4-mapped ipv6) and fail_cause.
// Throughput: one character per cycle; the checker state updates in the same
// cycle that a character is accepted, from the state registers and the character.
// Latency: the verdict is valid in the cycle after the last character is accepted.
// The verdict sits in a one-entry output register; req_if.ready drops only while
// that register holds a verdict the receiver has not taken, so a stalled receiver
// holds the character stream and the verdict stays stable until taken.
// Reset (synchronous, active high) empties the output register and returns the
// checkers to the start of a string; no clearing sweep is needed.
// depends on avp_pkg, avp_req_if, avp_rsp_if, avp_scan, avp_rsp_reg
`default_nettype none

module ip_address_text_validator_top (
   input  wire logic   clock,
   input  wire logic   reset,
   avp_req_if.sink     req_if,
   avp_rsp_if.source   rsp_if
);
   import avp_pkg::*;

   logic       can_take;
   logic       accept;
   logic       rsp_valid;
   result_type result;
   result_type rsp_data;

   // transaction accepted on the character channel
   assign req_if.ready = can_take;
   assign accept       = req_if.valid && can_take;

   avp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_if.char_code),
      .last_char (req_if.last_char),
      .result    (result)
   );

   avp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && req_if.last_char),
      .result    (result),
      .rsp_ready (rsp_if.ready),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // verdict channel
   assign rsp_if.valid      = rsp_valid;
   assign rsp_if.addr_valid = rsp_data.addr_valid;
   assign rsp_if.addr_kind  = rsp_data.addr_kind;
   assign rsp_if.fail_cause = rsp_data.fail_cause;

endmodule

`default_nettype wire

// ===== tb/avp_verdict_check.sv =====
// avp_verdict_check: watches the character and verdict channels of the address validator,
// predicts each verdict from the accepted characters and compares it with the block's output
// depends on avp_pkg, avp_req_if and avp_rsp_if
`timescale 1ns / 1ps

module avp_verdict_check (
   input  logic clock,
   input  logic reset,
   avp_req_if   req_mon,
   avp_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   verdicts_pending
);
   import avp_pkg::*;

   // dotted quad tracker
   logic [2:0] oct_digits;
   logic [9:0] oct_value;
   logic [2:0] oct_count;
   fail_type   oct_fail;

   // hex group tracker
   logic [3:0] grp_count;
   logic [2:0] grp_digits;
   logic       dbl_colon_seen;
   run_type    colon_state;
   fail_type   v6_fail;

   // kind decisions and "::ffff:" prefix tracking
   kind_type   first_kind;
   kind_type   tail_kind;
   prefix_type pfx;

   result_type verdict_queue[$];

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_hex_letter(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

   // the kind a single character points to
   function automatic kind_type char_class(input logic [7:0] c);
      if (c == CH_DOT)
         return KIND_V4;
      if (is_hex_letter(c) || c == CH_COLON)
         return KIND_V6;
      return KIND_NONE;
   endfunction

   task automatic clear_octets();
      oct_digits = 3'd0;
      oct_value  = 10'd0;
      oct_count  = 3'd1;
      oct_fail   = FAIL_NONE;
   endtask

   task automatic clear_scan();
      clear_octets();
      grp_count      = 4'd1;
      grp_digits     = 3'd0;
      dbl_colon_seen = 1'b0;
      colon_state    = RUN_NONE;
      v6_fail        = FAIL_NONE;
      first_kind     = KIND_NONE;
      tail_kind      = KIND_NONE;
      pfx            = PH_START;
   endtask

   // dotted quad step, first failure sticks
   task automatic feed_octets(input logic [7:0] c);
      int acc;
      if (oct_fail != FAIL_NONE)
         return;
      if (is_digit(c)) begin
         oct_digits++;
         acc = int'(oct_value) * 10 + int'(c) - int'(CH_ZERO);
         oct_value = acc[9:0];
      end else if (c == CH_DOT) begin
         if (oct_digits == 3'd0 || oct_value > OCTET_MAX) begin
            oct_fail = FAIL_FORMAT;
            return;
         end
         oct_count++;
         oct_digits = 3'd0;
         oct_value  = 10'd0;
      end else begin
         oct_fail = FAIL_CHAR;
         return;
      end
      if (oct_digits > QUAD_DIGIT_MAX || oct_count > QUAD_GROUPS)
         oct_fail = FAIL_FORMAT;
   endtask

   function automatic fail_type octet_verdict();
      if (oct_fail != FAIL_NONE)
         return oct_fail;
      if (oct_count != QUAD_GROUPS || oct_digits == 3'd0 || oct_value > OCTET_MAX)
         return FAIL_FORMAT;
      return FAIL_NONE;
   endfunction

   // hex group step, first failure sticks
   task automatic feed_groups(input logic [7:0] c);
      if (v6_fail != FAIL_NONE)
         return;
      // a single leading colon must be followed by a second one
      if (pfx == PH_ONE_COLON && c != CH_COLON) begin
         v6_fail = FAIL_FORMAT;
         return;
      end
      if (is_digit(c) || is_hex_letter(c)) begin
         colon_state = RUN_NONE;
         grp_digits++;
         if (grp_digits > HEX_DIGIT_MAX)
            v6_fail = FAIL_FORMAT;
      end else if (c == CH_COLON) begin
         case (colon_state)
            RUN_NONE: begin
               colon_state = RUN_ONE;
               grp_count++;
               grp_digits = 3'd0;
               if (grp_count > HEX_GROUPS)
                  v6_fail = FAIL_FORMAT;
            end
            RUN_ONE: begin
               if (dbl_colon_seen) begin
                  v6_fail = FAIL_FORMAT;
                  return;
               end
               dbl_colon_seen = 1'b1;
               colon_state    = RUN_TWO;
            end
            default: v6_fail = FAIL_FORMAT;
         endcase
      end else begin
         v6_fail = FAIL_CHAR;
      end
   endtask

   function automatic fail_type group_verdict();
      if (v6_fail != FAIL_NONE)
         return v6_fail;
      if (pfx == PH_ONE_COLON)
         return FAIL_FORMAT;
      if (grp_digits == 3'd0 && colon_state != RUN_TWO)
         return FAIL_FORMAT;
      if (dbl_colon_seen && grp_count > HEX_GROUPS_ZR)
         return FAIL_FORMAT;
      if (!dbl_colon_seen && grp_count != HEX_GROUPS)
         return FAIL_FORMAT;
      return FAIL_NONE;
   endfunction

   // one character through all trackers; a verdict comes only on the last one
   task automatic scan_char(input logic [7:0] c, input logic last,
                            output logic produced, output result_type verdict);
      kind_type cls;
      fail_type cause;
      kind_type kind;
      cls = char_class(c);
      produced = 1'b0;
      verdict  = '0;

      feed_groups(c);
      if (first_kind == KIND_NONE)
         first_kind = cls;

      // "::ffff:" prefix walk
      case (pfx)
         PH_START, PH_ONE_COLON, PH_F4:
            pfx = (c == CH_COLON) ? prefix_type'(pfx + 4'd1) : PH_DEAD;
         PH_TWO_COLON, PH_F1, PH_F2, PH_F3:
            pfx = (c == CH_LO_F || c == CH_UP_F) ? prefix_type'(pfx + 4'd1) : PH_DEAD;
         PH_PREFIX: begin
            if (c == CH_COLON) begin
               pfx = PH_DEAD;
            end else begin
               clear_octets();
               tail_kind = KIND_NONE;
               pfx       = PH_MAPPED;
            end
         end
         default: ;
      endcase
      feed_octets(c);
      if (pfx == PH_MAPPED && tail_kind == KIND_NONE)
         tail_kind = cls;

      if (last) begin
         if (pfx == PH_MAPPED && tail_kind == KIND_V4) begin
            kind  = KIND_MAPPED;
            cause = octet_verdict();
         end else if (first_kind == KIND_V4) begin
            kind  = KIND_V4;
            cause = octet_verdict();
         end else if (first_kind == KIND_V6) begin
            kind  = KIND_V6;
            cause = group_verdict();
         end else begin
            kind  = KIND_NONE;
            cause = FAIL_UNDET;
         end
         verdict.addr_valid = (cause == FAIL_NONE);
         verdict.addr_kind  = kind;
         verdict.fail_cause = cause;
         produced = 1'b1;
         clear_scan();
      end
   endtask

   // accept characters, then compare verdicts against the oldest prediction
   always @(posedge clock) begin
      logic       got_verdict;
      result_type predicted;
      result_type oldest;
      if (reset) begin
         clear_scan();
         verdict_queue.delete();
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            scan_char(req_mon.char_code, req_mon.last_char, got_verdict, predicted);
            if (got_verdict)
               verdict_queue.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected verdict transaction: valid %0d kind %0d cause %0d",
                           rsp_mon.addr_valid, rsp_mon.addr_kind, rsp_mon.fail_cause);
            end else begin
               oldest = verdict_queue.pop_front();
               if (rsp_mon.addr_valid !== oldest.addr_valid ||
                   rsp_mon.addr_kind  !== oldest.addr_kind  ||
                   rsp_mon.fail_cause !== oldest.fail_cause) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"verdict mismatch: expected valid %0d kind %0d cause %0d,",
                               " got valid %0d kind %0d cause %0d"},
                              oldest.addr_valid, oldest.addr_kind, oldest.fail_cause,
                              rsp_mon.addr_valid, rsp_mon.addr_kind, rsp_mon.fail_cause);
               end
            end
         end
      end
      verdicts_pending = verdict_queue.size();
   end

endmodule

// ===== tb/tb.sv =====
// tb: top of the address validator testbench; drives address strings one character per
// transaction under several idle and stall mixes, and gives the final verdict
// depends on avp_pkg, avp_req_if, avp_rsp_if, avp_verdict_check and the block's rtl
`timescale 1ns / 1ps

module tb;
   import avp_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_CYCLES     = 60;
   localparam int CHARS_PER_PHASE = 150;

   logic clock;
   logic reset;
   int   verdict_errors;
   int   verdicts_pending;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   chars_sent;
   int   cycle_count = 0;
   logic hold_request;
   logic hold_off;
   logic [7:0] text[$];

   avp_req_if req_if ();
   avp_rsp_if rsp_if ();

   ip_address_text_validator_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   avp_verdict_check verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .mismatch_count   (verdict_errors),
      .verdicts_pending (verdicts_pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ip_address_text_validator_top test failed");
         $finish;
      end
   end

   // long receiver hold-off, once, so the output register fills and blocks the input
   initial begin
      hold_off = 1'b0;
      wait (hold_request);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // receiver ready
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // one character transaction, with random idle cycles ahead of it
   task automatic push_char(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= ch;
      req_if.last_char <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++)
         push_char(text[i], i == text.size() - 1);
      chars_sent += text.size();
   endtask

   task automatic send_str(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
      send_text();
   endtask

   // sender stops until every verdict has come back
   task automatic wait_for_verdicts();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (verdicts_pending != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] hex_char(input int d);
      if (d < 10)
         return CH_ZERO + 8'(d);
      return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
   endfunction

   function automatic logic [7:0] random_char();
      case ($urandom_range(5))
         0:       return CH_ZERO + 8'($urandom_range(9));
         1:       return hex_char($urandom_range(10, 15));
         2:       return CH_COLON;
         3:       return CH_DOT;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic put_hex_group();
      int len;
      len = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
      repeat (len) text.push_back(hex_char($urandom_range(15)));
   endtask

   task automatic put_groups(input int n);
      for (int i = 0; i < n; i++) begin
         if (i > 0)
            text.push_back(CH_COLON);
         put_hex_group();
      end
   endtask

   // decimal octet, mostly in range, sometimes too large or too long
   task automatic put_octet();
      int  r;
      int  v;
      logic pad;
      r   = $urandom_range(19);
      pad = ($urandom_range(7) == 0);
      if (r == 1) begin
         repeat (4) text.push_back(CH_ZERO + 8'($urandom_range(9)));
         return;
      end
      if (r == 0)
         v = $urandom_range(256, 999);
      else if (r == 2)
         v = 255;
      else if (r == 3)
         v = 0;
      else
         v = $urandom_range(255);
      if (v >= 100 || pad)
         text.push_back(CH_ZERO + 8'(v / 100));
      if (v >= 10 || pad)
         text.push_back(CH_ZERO + 8'((v / 10) % 10));
      text.push_back(CH_ZERO + 8'(v % 10));
   endtask

   task automatic put_quad();
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4;
      for (int i = 0; i < n; i++) begin
         if (i > 0)
            text.push_back(CH_DOT);
         put_octet();
      end
   endtask

   // mostly well-formed addresses with random content, some noise and corruption
   task automatic compose_address();
      int pick;
      int n_lead;
      int n_trail;
      int n_f;
      text.delete();
      pick = $urandom_range(99);
      if (pick < 20) begin
         put_quad();
      end else if (pick < 40) begin
         put_groups(($urandom_range(9) == 0) ? $urandom_range(7, 9) : 8);
      end else if (pick < 62) begin
         // compressed form
         n_lead  = $urandom_range(3);
         n_trail = $urandom_range(6 - n_lead);
         if ($urandom_range(9) == 0)
            n_trail += $urandom_range(1, 3);
         put_groups(n_lead);
         text.push_back(CH_COLON);
         text.push_back(CH_COLON);
         put_groups(n_trail);
         if ($urandom_range(9) == 0) begin
            text.push_back(CH_COLON);
            text.push_back(CH_COLON);
            put_groups($urandom_range(2));
         end
      end else if (pick < 80) begin
         // ipv4-mapped prefix
         n_f = ($urandom_range(9) == 0) ? 3 : 4;
         text.push_back(CH_COLON);
         text.push_back(CH_COLON);
         repeat (n_f) text.push_back($urandom_range(1) ? CH_UP_F : CH_LO_F);
         text.push_back(CH_COLON);
         if ($urandom_range(7) == 0)
            put_groups($urandom_range(1, 3));
         else
            put_quad();
      end else begin
         repeat ($urandom_range(1, 6)) text.push_back(random_char());
      end
      if ($urandom_range(99) < 15)
         text[$urandom_range(text.size() - 1)] = random_char();
   endtask

   // stimulus
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = 8'h00;
      req_if.last_char = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      chars_sent       = 0;
      hold_request     = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings: trailing and lone colons, triple colon, second "::",
      // digits only, mapped form, octet extremes, nul and non-ascii bytes
      send_str("::");
      send_str(":");
      send_str(":1");
      send_str(":::");
      send_str("7");
      send_str("0.0.0.255");
      send_str("::ffff:1.2.3.4");
      send_str("1::");
      send_str("a::b::c");
      text.delete();
      text.push_back(CH_LO_A);
      text.push_back(8'h00);
      send_text();
      text.delete();
      text.push_back(8'hFF);
      send_text();
      wait_for_verdicts();

      // random strings under each idle and stall mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         chars_sent = 0;
         while (chars_sent < CHARS_PER_PHASE) begin
            compose_address();
            send_text();
         end
         wait_for_verdicts();
      end

      // settle, then the verdict
      repeat (10) @(negedge clock);
      if (verdict_errors == 0)
         $display("ip_address_text_validator_top test passed");
      else
         $display("ip_address_text_validator_top test failed");
      $finish;
   end

endmodule
